[src/lqpm_pkg.sv]
package lqpm_pkg;

	// Width of the entry index fields on the ports
	localparam int unsigned FIELD_W = 5;
	localparam int unsigned FUNC_W = 3;
	localparam int unsigned ENTRIES_DEF = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC   = 3'd0,
		FN_RELEASE = 3'd1,
		FN_ENQUEUE = 3'd2,
		FN_DEQUEUE = 3'd3,
		FN_UNLINK  = 3'd4,
		FN_PEEK    = 3'd5
	} func_t;

endpackage

[src/lqpm_ram.sv]
module lqpm_ram #(
	parameter int unsigned WIDTH = 11,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/linked_queue_pool_manager.sv]
// Linked queue pool manager: circular doubly linked queues over one link RAM.
// Each link update is a read then a write-back; an output stall holds the result back.
// Throughput: one word at a time; the next word is taken once the sequencer is idle.
// Reset: asynchronous; all entries on the free list in index order, no clearing pass.
module linked_queue_pool_manager #(
	parameter int unsigned ENTRIES = lqpm_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lqpm_pkg::FUNC_W-1:0]   func,
	input  logic [lqpm_pkg::FIELD_W-1:0]  queue_tail,
	input  logic                          queue_nonempty,
	input  logic [lqpm_pkg::FIELD_W-1:0]  entry,
	input  logic                          entry_valid,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lqpm_pkg::FIELD_W-1:0]  found_entry,
	output logic                          found_valid,
	output logic [lqpm_pkg::FIELD_W-1:0]  new_tail,
	output logic                          new_nonempty
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	// RAM word: {linked flag, prev link, next link}
	localparam int unsigned WW = 2 * IW + 1;
	localparam int unsigned FW = lqpm_pkg::FIELD_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_HEAD, ST_PEEK,
		ST_I1, ST_I2, ST_I3, ST_I4, ST_I5,
		ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6, ST_R7,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [lqpm_pkg::FUNC_W-1:0] func_q;
	logic [FW-1:0]     tail_q;      // caller queue tail
	logic              ne_q;        // caller queue non-empty
	logic [FW-1:0]     ent_q;
	logic              ent_v_q;
	logic              use_free_q;  // operation works on the free list
	logic [IW-1:0]     ftail_q;
	logic              fne_q;
	logic [IW-1:0]     p_q, n_q, v_q;
	logic [IW-1:0]     found_q;
	logic              fvalid_q;

	// output register
	logic              out_valid_q;
	logic [FW-1:0]     found_out_q;
	logic              fvalid_out_q;
	logic [FW-1:0]     tail_out_q;
	logic              ne_out_q;

	// link RAM and per-entry written bits (unwritten entries read as reset value)
	logic [ENTRIES-1:0] vld_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_addr_s1;
	logic [IW-1:0]      rd_addr;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [WW-1:0]      mem_wdata;
	logic [WW-1:0]      ram_rdata;
	logic [WW-1:0]      rword;
	logic [IW-1:0]      r_next, r_prev;
	logic               r_flag;
	logic [IW-1:0]      rst_next, rst_prev;

	logic [IW-1:0]      sel_t;
	logic               sel_ne;
	logic               ent_ok, q_ok, is_remove, in_acc, out_acc;
	logic               fin_go;

	function automatic logic [WW-1:0] mk_word(logic f, logic [IW-1:0] pv, logic [IW-1:0] nx);
		return {f, pv, nx};
	endfunction

	lqpm_ram #(.WIDTH(WW), .DEPTH(2 ** IW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// reset contents of the entry just read
	always_comb begin
		rst_next = (32'(rd_addr_s1) + 1 >= ENTRIES) ? '0 : IW'(32'(rd_addr_s1) + 1);
		rst_prev = (rd_addr_s1 == '0) ? IW'(ENTRIES - 1) : IW'(32'(rd_addr_s1) - 1);
		rword    = rd_vld_s1 ? ram_rdata : mk_word(1'b1, rst_prev, rst_next);
		r_next   = rword[IW-1:0];
		r_prev   = rword[2*IW-1:IW];
		r_flag   = rword[2*IW];
	end

	assign sel_t  = use_free_q ? ftail_q : IW'(tail_q);
	assign sel_ne = use_free_q ? fne_q : ne_q;
	assign ent_ok = ent_v_q && (32'(ent_q) < ENTRIES);
	assign q_ok   = !ne_q || (32'(tail_q) < ENTRIES);
	assign is_remove = (func_q == lqpm_pkg::FN_UNLINK);
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	// result moves into the output register this cycle
	assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign found_entry  = found_out_q;
	assign found_valid  = fvalid_out_q;
	assign new_tail     = tail_out_q;
	assign new_nonempty = ne_out_q;

	// read address per step
	always_comb begin
		unique case (state_q)
			ST_DISP: rd_addr = is_remove ? p_q : sel_t;
			ST_I2:   rd_addr = n_q;
			ST_R0:   rd_addr = p_q;
			ST_R2:   rd_addr = v_q;
			ST_R4:   rd_addr = n_q;
			ST_R6:   rd_addr = p_q;
			default: rd_addr = sel_t;
		endcase
	end

	// write-back per step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = p_q;
		mem_wdata = mk_word(1'b1, p_q, p_q);
		unique case (state_q)
			ST_DISP: begin
				// insert into an empty queue: entry links to itself
				mem_we = !is_remove && (func_q == lqpm_pkg::FN_RELEASE ||
					(func_q == lqpm_pkg::FN_ENQUEUE && q_ok)) && ent_ok && !sel_ne;
			end
			ST_I1: begin
				mem_we    = 1'b1;
				mem_wdata = mk_word(1'b1, sel_t, r_next);
			end
			ST_I3: begin
				mem_we    = 1'b1;
				mem_waddr = n_q;
				mem_wdata = mk_word(r_flag, p_q, r_next);
			end
			ST_I5: begin
				mem_we    = 1'b1;
				mem_waddr = sel_t;
				mem_wdata = mk_word(r_flag, r_prev, p_q);
			end
			ST_R1: begin
				// lone entry: only its flag drops
				mem_we    = r_flag && r_next == p_q && r_prev == p_q;
				mem_wdata = mk_word(1'b0, r_prev, r_next);
			end
			ST_R3: begin
				mem_we    = 1'b1;
				mem_waddr = v_q;
				mem_wdata = mk_word(r_flag, r_prev, n_q);
			end
			ST_R5: begin
				mem_we    = 1'b1;
				mem_waddr = n_q;
				mem_wdata = mk_word(r_flag, v_q, r_next);
			end
			ST_R7: begin
				mem_we    = 1'b1;
				mem_wdata = mk_word(1'b0, r_prev, r_next);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vld_q        <= '0;
			ftail_q      <= IW'(ENTRIES - 1);
			fne_q        <= 1'b1;
			out_valid_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_addr_s1   <= '0;
			func_q       <= '0;
			tail_q       <= '0;
			ne_q         <= 1'b0;
			ent_q        <= '0;
			ent_v_q      <= 1'b0;
			use_free_q   <= 1'b0;
			p_q          <= '0;
			n_q          <= '0;
			v_q          <= '0;
			found_q      <= '0;
			fvalid_q     <= 1'b0;
			found_out_q  <= '0;
			fvalid_out_q <= 1'b0;
			tail_out_q   <= '0;
			ne_out_q     <= 1'b0;
		end else begin
			rd_vld_s1  <= vld_q[rd_addr];
			rd_addr_s1 <= rd_addr;
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			if (out_acc && !fin_go) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						func_q     <= func;
						tail_q     <= queue_tail;
						ne_q       <= queue_nonempty;
						ent_q      <= entry;
						ent_v_q    <= entry_valid;
						p_q        <= IW'(entry);
						use_free_q <= (func == lqpm_pkg::FN_ALLOC) ||
							(func == lqpm_pkg::FN_RELEASE);
						found_q    <= '0;
						fvalid_q   <= 1'b0;
						state_q    <= ST_DISP;
					end
				end
				ST_DISP: begin
					unique case (func_q)
						lqpm_pkg::FN_ALLOC:
							state_q <= fne_q ? ST_HEAD : ST_FIN;
						lqpm_pkg::FN_RELEASE, lqpm_pkg::FN_ENQUEUE: begin
							if (!ent_ok || (func_q == lqpm_pkg::FN_ENQUEUE && !q_ok)) begin
								state_q <= ST_FIN;
							end else if (!sel_ne) begin
								if (use_free_q) begin
									ftail_q <= p_q;
									fne_q   <= 1'b1;
								end else begin
									tail_q <= FW'(p_q);
									ne_q   <= 1'b1;
								end
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_I1;
							end
						end
						lqpm_pkg::FN_DEQUEUE:
							state_q <= (ne_q && q_ok) ? ST_HEAD : ST_FIN;
						lqpm_pkg::FN_UNLINK:
							state_q <= (ent_ok && q_ok && ne_q) ? ST_R1 : ST_FIN;
						lqpm_pkg::FN_PEEK:
							state_q <= (ne_q && q_ok) ? ST_PEEK : ST_FIN;
						default:
							state_q <= ST_FIN;
					endcase
				end
				ST_PEEK: begin
					found_q  <= r_next;
					fvalid_q <= 1'b1;
					state_q  <= ST_FIN;
				end
				ST_HEAD: begin
					p_q     <= r_next;
					state_q <= ST_R0;
				end
				ST_I1: begin
					n_q     <= r_next;
					state_q <= ST_I2;
				end
				ST_I2: state_q <= ST_I3;
				ST_I3: state_q <= ST_I4;
				ST_I4: state_q <= ST_I5;
				ST_I5: begin
					if (use_free_q) begin
						ftail_q <= p_q;
					end else begin
						tail_q <= FW'(p_q);
					end
					state_q <= ST_FIN;
				end
				ST_R0: state_q <= ST_R1;
				ST_R1: begin
					if (!r_flag) begin
						state_q <= ST_FIN;
					end else if (r_next == p_q && r_prev == p_q) begin
						if (use_free_q) begin
							fne_q <= 1'b0;
						end else begin
							ne_q <= 1'b0;
						end
						found_q  <= p_q;
						fvalid_q <= 1'b1;
						state_q  <= ST_FIN;
					end else begin
						n_q     <= r_next;
						v_q     <= r_prev;
						state_q <= ST_R2;
					end
				end
				ST_R2: state_q <= ST_R3;
				ST_R3: state_q <= ST_R4;
				ST_R4: state_q <= ST_R5;
				ST_R5: begin
					if (sel_t == p_q) begin
						if (use_free_q) begin
							ftail_q <= v_q;
						end else begin
							tail_q <= FW'(v_q);
						end
					end
					state_q <= ST_R6;
				end
				ST_R6: state_q <= ST_R7;
				ST_R7: begin
					found_q  <= p_q;
					fvalid_q <= 1'b1;
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					// hand over once the output register is free
					if (fin_go) begin
						out_valid_q  <= 1'b1;
						found_out_q  <= FW'(found_q);
						fvalid_out_q <= fvalid_q;
						tail_out_q   <= tail_q;
						ne_out_q     <= ne_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("result overwritten while stalled");

	// link RAM is only written while a word is in progress
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_IDLE && state_q != ST_FIN))
		else $error("link write outside an operation");

	// an accepted word starts decoding next cycle
	a_acc_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DISP))
		else $error("accepted word not dispatched");

	// a null result carries index zero
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !fvalid_out_q) |-> (found_out_q == '0))
		else $error("null result with nonzero index");

endmodule

[tb/lqpm_tb_pkg.sv]
`timescale 1ns / 1ps
package lqpm_tb_pkg;
	import lqpm_pkg::*;

	localparam int unsigned NENT = ENTRIES_DEF;

	typedef struct packed {
		logic [FIELD_W-1:0] found;
		logic               fvalid;
		logic [FIELD_W-1:0] tail;
		logic               nonempty;
	} pool_res_t;

	// Shadow of the link pool plus the words still owed by the block
	class PoolScoreboard;
		logic [FIELD_W-1:0] nxt [NENT];
		logic [FIELD_W-1:0] prv [NENT];
		bit                 linked [NENT];
		logic [FIELD_W-1:0] free_tail;
		logic               free_ne;
		pool_res_t          owed_q [$];
		int                 errors;

		function new();
			for (int i = 0; i < NENT; i++) begin
				nxt[i] = FIELD_W'((i + 1) % NENT);
				prv[i] = FIELD_W'((i + NENT - 1) % NENT);
				linked[i] = 1;
			end
			free_tail = FIELD_W'(NENT - 1);
			free_ne = 1;
			errors = 0;
		endfunction

		function void link_in(inout logic [FIELD_W-1:0] t, inout logic ne,
				input logic [FIELD_W-1:0] p);
			logic [FIELD_W-1:0] old;
			if (!ne) begin
				t = p;
				ne = 1;
				nxt[p] = p;
				prv[p] = p;
			end else begin
				old = t;
				nxt[p] = nxt[old];
				prv[p] = old;
				prv[nxt[old]] = p;
				nxt[old] = p;
				t = p;
			end
			linked[p] = 1;
		endfunction

		function bit link_out(inout logic [FIELD_W-1:0] t, inout logic ne,
				input logic [FIELD_W-1:0] p);
			logic [FIELD_W-1:0] n, v;
			if (!ne || !linked[p])
				return 0;
			if (nxt[p] == p && prv[p] == p) begin
				ne = 0;
			end else begin
				n = nxt[p];
				v = prv[p];
				nxt[v] = n;
				prv[n] = v;
				if (t == p)
					t = v;
			end
			linked[p] = 0;
			return 1;
		endfunction

		// Accepted input word: update shadow, queue the expected output
		function pool_res_t note_word(logic [FUNC_W-1:0] f, logic [FIELD_W-1:0] t,
				logic ne, logic [FIELD_W-1:0] e, logic ev);
			pool_res_t r;
			logic [FIELD_W-1:0] hd;
			bit ent_ok;
			bit q_ok;
			ent_ok = ev && (int'(e) < NENT);
			q_ok = !ne || (int'(t) < NENT);
			r.found = '0;
			r.fvalid = 0;
			case (f)
				FN_ALLOC: begin
					if (free_ne) begin
						hd = nxt[free_tail];
						if (link_out(free_tail, free_ne, hd)) begin
							r.found = hd;
							r.fvalid = 1;
						end
					end
				end
				FN_RELEASE: if (ent_ok) link_in(free_tail, free_ne, e);
				FN_ENQUEUE: if (ent_ok && q_ok) link_in(t, ne, e);
				FN_DEQUEUE: begin
					if (ne && q_ok) begin
						hd = nxt[t];
						if (link_out(t, ne, hd)) begin
							r.found = hd;
							r.fvalid = 1;
						end
					end
				end
				FN_UNLINK: begin
					if (ent_ok && q_ok && link_out(t, ne, e)) begin
						r.found = e;
						r.fvalid = 1;
					end
				end
				FN_PEEK: begin
					if (ne && q_ok) begin
						r.found = nxt[t];
						r.fvalid = 1;
					end
				end
				default: ;
			endcase
			r.tail = t;
			r.nonempty = ne;
			owed_q.push_back(r);
			return r;
		endfunction

		function void check_word(pool_res_t got);
			pool_res_t want;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected output word %p", $time, got);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (got.found !== want.found) begin
				$display("%0t: found_entry exp %0d got %0d", $time, want.found, got.found);
				errors++;
			end
			if (got.fvalid !== want.fvalid) begin
				$display("%0t: found_valid exp %0d got %0d", $time, want.fvalid, got.fvalid);
				errors++;
			end
			if (got.tail !== want.tail) begin
				$display("%0t: new_tail exp %0d got %0d", $time, want.tail, got.tail);
				errors++;
			end
			if (got.nonempty !== want.nonempty) begin
				$display("%0t: new_nonempty exp %0d got %0d", $time, want.nonempty,
					got.nonempty);
				errors++;
			end
		endfunction
	endclass

endpackage

[tb/linked_queue_pool_manager_tb.sv]
`timescale 1ns / 1ps
module linked_queue_pool_manager_tb;
	import lqpm_pkg::*;
	import lqpm_tb_pkg::*;

	localparam int LIMIT = 3000000;	// cycles; worst case is far below this
	localparam int NQ = 3;	// caller-side queues tracked by the stimulus
	localparam int HELD = -1;	// owner code: allocated, on no queue
	localparam int LOOSE = NQ;	// owner code: free list or unknown
	// func codes with no operation behind them
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [FIELD_W-1:0] queue_tail = '0;
	logic queue_nonempty = 0;
	logic [FIELD_W-1:0] entry = '0;
	logic entry_valid = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [FIELD_W-1:0] found_entry;
	logic found_valid;
	logic [FIELD_W-1:0] new_tail;
	logic new_nonempty;

	linked_queue_pool_manager uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	PoolScoreboard pool_sb = new();
	int cycles = 0;
	int send_idle_pct = 0;	// chance per cycle the sender inserts a gap
	int recv_stall_pct = 0;	// chance per cycle the receiver stalls
	logic hold_off = 0;	// long receiver hold-off to back the block up

	// caller queues as the stimulus sees them, kept from predicted results
	logic [FIELD_W-1:0] q_tail [NQ];
	logic q_ne [NQ];
	int owner [NENT];

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** linked_queue_pool_manager: FAILED **");
			$finish;
		end
	end

	// receiver: take words, decide next cycle's stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				pool_sb.check_word({found_entry, found_valid, new_tail, new_nonempty});
			out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// one word through the input channel; returns the predicted output
	task automatic push_word(logic [FUNC_W-1:0] f, logic [FIELD_W-1:0] t, logic ne,
			logic [FIELD_W-1:0] e, logic ev, output pool_res_t r);
		func <= f;
		queue_tail <= t;
		queue_nonempty <= ne;
		entry <= e;
		entry_valid <= ev;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		r = pool_sb.note_word(f, t, ne, e, ev);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// random entry with the given owner, or -1 if none
	function automatic int pick_owned(int who);
		int cand [$];
		for (int i = 0; i < NENT; i++)
			if (owner[i] == who)
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(cand.size() - 1)];
	endfunction

	task automatic noise_word();
		pool_res_t r;
		push_word(FUNC_W'($urandom), FIELD_W'($urandom), 1'($urandom),
			FIELD_W'($urandom), 1'($urandom), r);
	endtask

	// well-formed operation on caller queue qi
	task automatic pool_op(int kind, int qi);
		pool_res_t r;
		int e;
		case (kind)
			1: begin	// release a held entry
				e = pick_owned(HELD);
				if (e < 0) begin
					pool_op(0, qi);
				end else begin
					push_word(FN_RELEASE, FIELD_W'($urandom), 1'($urandom), FIELD_W'(e), 1, r);
					owner[e] = LOOSE;
				end
			end
			2: begin	// enqueue a held entry
				e = pick_owned(HELD);
				if (e < 0) begin
					pool_op(0, qi);
				end else begin
					push_word(FN_ENQUEUE, q_tail[qi], q_ne[qi], FIELD_W'(e), 1, r);
					q_tail[qi] = r.tail;
					q_ne[qi] = r.nonempty;
					owner[e] = qi;
				end
			end
			3, 4: begin	// dequeue head or unlink a member
				e = pick_owned(qi);
				if (kind == 3 || e < 0)
					push_word(FN_DEQUEUE, q_tail[qi], q_ne[qi], FIELD_W'($urandom),
						1'($urandom), r);
				else
					push_word(FN_UNLINK, q_tail[qi], q_ne[qi], FIELD_W'(e), 1, r);
				q_tail[qi] = r.tail;
				q_ne[qi] = r.nonempty;
				if (r.fvalid)
					owner[r.found] = HELD;
			end
			5: push_word(FN_PEEK, q_tail[qi], q_ne[qi], FIELD_W'($urandom), 1'($urandom), r);
			default: begin	// allocate from the free list
				push_word(FN_ALLOC, FIELD_W'($urandom), 1'($urandom), FIELD_W'($urandom),
					1'($urandom), r);
				if (r.fvalid)
					owner[r.found] = HELD;
			end
		endcase
	endtask

	task automatic random_phase(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 12) begin
				noise_word();
			end else begin
				k = $urandom_range(5);
				// keep a moderate number of entries in hand
				if (pick_owned(LOOSE) < 0 && k == 0)
					k = 1 + $urandom_range(1);
				pool_op(k, $urandom_range(NQ - 1));
			end
		end
	endtask

	initial begin
		pool_res_t r;
		for (int i = 0; i < NENT; i++)
			owner[i] = LOOSE;
		for (int i = 0; i < NQ; i++) begin
			q_tail[i] = '0;
			q_ne[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty-queue ops, lone entry, unlinked removal, null entry, unused codes
		push_word(FN_PEEK, 5'd31, 0, 5'd0, 0, r);
		push_word(FN_DEQUEUE, 5'd0, 0, 5'd31, 1, r);
		pool_op(0, 0);
		pool_op(0, 0);
		pool_op(0, 0);
		pool_op(2, 0);	// first entry into empty queue
		pool_op(5, 0);
		pool_op(3, 0);	// lone entry empties the queue
		push_word(FN_UNLINK, 5'd0, 1, 5'd0, 1, r);	// entry not linked
		push_word(FN_RELEASE, 5'd31, 1, 5'd31, 0, r);	// null entry
		push_word(FN_ENQUEUE, 5'd0, 0, 5'd31, 0, r);
		push_word(FN_UNLINK, 5'd31, 1, 5'd31, 0, r);
		push_word(FN_SPARE_LO, 5'd31, 1, 5'd31, 1, r);
		push_word(FN_SPARE_HI, 5'd10, 0, 5'd21, 0, r);
		pool_op(2, 1);
		pool_op(2, 1);
		pool_op(2, 1);
		pool_op(4, 1);
		pool_op(5, 1);
		pool_op(3, 1);
		pool_op(1, 0);
		// enqueue of an entry still on the free list
		push_word(FN_ENQUEUE, 5'd0, 0, 5'd20, 1, r);
		owner[20] = LOOSE;
		q_tail[2] = r.tail;
		q_ne[2] = r.nonempty;

		// random: no idling, sender idle, receiver stall with a long hold-off, both
		random_phase(450);
		send_idle_pct = 67;
		random_phase(450);
		send_idle_pct = 0;
		recv_stall_pct = 67;
		hold_off <= 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off <= 0;
			end
			random_phase(450);
		join
		send_idle_pct = 19;
		recv_stall_pct = 19;
		random_phase(450);
		in_valid <= 0;
		recv_stall_pct = 0;

		while (pool_sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (pool_sb.errors == 0)
			$display("** linked_queue_pool_manager: PASSED **");
		else
			$display("** linked_queue_pool_manager: FAILED **");
		$finish;
	end

endmodule
